// ===== design/pelt_pkg.sv =====
// Shared constants, decay table and divider request and response types for the load tracker.
package pelt_pkg;

  localparam int unsigned PERIOD_UNITS = 1024;
  localparam int unsigned CAP_SHIFT    = 10;
  localparam int unsigned AVG_MAX      = 47742;
  localparam int unsigned MIN_DIVIDER  = AVG_MAX - PERIOD_UNITS;
  localparam int unsigned MAX_PERIODS  = 2016;
  localparam int unsigned DIV_BITS     = 16;
  localparam int unsigned DIVIDEND_W   = 64;

  typedef struct packed {
    logic                  valid;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIV_BITS-1:0]   divisor;
  } pelt_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } pelt_div_rsp_t;

  function automatic logic [31:0] y_inv(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'hffffffff;
      5'd1:  v = 32'hfa83b2da;
      5'd2:  v = 32'hf5257d14;
      5'd3:  v = 32'hefe4b99a;
      5'd4:  v = 32'heac0c6e6;
      5'd5:  v = 32'he5b906e6;
      5'd6:  v = 32'he0ccdeeb;
      5'd7:  v = 32'hdbfbb796;
      5'd8:  v = 32'hd744fcc9;
      5'd9:  v = 32'hd2a81d91;
      5'd10: v = 32'hce248c14;
      5'd11: v = 32'hc9b9bd85;
      5'd12: v = 32'hc5672a10;
      5'd13: v = 32'hc12c4cc9;
      5'd14: v = 32'hbd08a39e;
      5'd15: v = 32'hb8fbaf46;
      5'd16: v = 32'hb504f333;
      5'd17: v = 32'hb123f581;
      5'd18: v = 32'had583ee9;
      5'd19: v = 32'ha9a15ab4;
      5'd20: v = 32'ha5fed6a9;
      5'd21: v = 32'ha2704302;
      5'd22: v = 32'h9ef5325f;
      5'd23: v = 32'h9b8d39b9;
      5'd24: v = 32'h9837f050;
      5'd25: v = 32'h94f4efa8;
      5'd26: v = 32'h91c3d373;
      5'd27: v = 32'h8ea4398a;
      5'd28: v = 32'h8b95c1e3;
      5'd29: v = 32'h88980e80;
      5'd30: v = 32'h85aac367;
      default: v = 32'h82cd8698;
    endcase
    return v;
  endfunction

endpackage

// ===== design/pelt_load_tracker.sv =====
// Per-entity load tracker: decays and accumulates load sums, recomputes averages.
// A backwards or sub-period step goes straight to the result. Otherwise the step accumulates
// the new contribution; on a period crossing it first decays five values, then forms the
// load-average product and runs three divides. A new request is taken only in idle, once the
// last result is in the output register; the shared 32x32 multiplier and the divider hold it.
// Synchronous active-low reset clears all sums and averages.
module pelt_load_tracker
  import pelt_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_data,     // halflife_shift
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // now_ns[63:0], load_weight, runnable_weight, running, zero fill
  input  logic [((64+2*WEIGHT_BITS+1+7)/8)*8-1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // load_average, runnable_average, util_average
  output logic [95:0]            out_tdata,
  // updated
  output logic                   out_tuser
);

  localparam logic [2:0] SEL_LOAD = 3'd0;
  localparam logic [2:0] SEL_RUN  = 3'd1;
  localparam logic [2:0] SEL_UTIL = 3'd2;
  localparam logic [2:0] SEL_D1   = 3'd3;
  localparam logic [2:0] SEL_MAX  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUB, ST_PREP, ST_DEC_SH, ST_DEC_LO, ST_DEC_HI, ST_DEC_SUM,
    ST_ACC_L, ST_ACC_LW, ST_ACC_RW, ST_LM_LO, ST_LM_HI, ST_LM_SUM,
    ST_DIVL_S, ST_DIVL_W, ST_DIVR_S, ST_DIVR_W, ST_DIVU_S, ST_DIVU_W, ST_OUT
  } state_t;

  state_t                 state_r;
  logic [1:0]             shift_r;
  logic [63:0]            last_time_r;
  logic [9:0]             partial_r;
  logic [63:0]            load_accum_r;
  logic [63:0]            runnable_accum_r;
  logic [31:0]            util_accum_r;
  logic [31:0]            load_mean_r;
  logic [31:0]            runnable_mean_r;
  logic [31:0]            util_mean_r;
  logic                   out_valid_r;
  logic [95:0]            out_data_r;
  logic                   out_user_r;

  logic [63:0]            now_r;
  logic [WEIGHT_BITS-1:0] load_r;
  logic [WEIGHT_BITS-1:0] runnable_r;
  logic                   running_r;
  logic [63:0]            dsh_r;
  logic [9:0]             rem_r;
  logic                   has_per_r;
  logic                   per_zero_r;
  logic [5:0]             pshift_r;
  logic [4:0]             pidx_r;
  logic [31:0]            contrib_r;
  logic [31:0]            c1_r;
  logic [2:0]             sel_r;
  logic [63:0]            sh_r;
  logic [31:0]            tmp_r;
  logic [63:0]            lm_r;
  logic [63:0]            mul_r;
  logic                   upd_r;

  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            dec_val;
  logic [63:0]            delta;
  logic [63:0]            dtot;
  logic [53:0]            periods;
  logic [63:0]            dec_res;
  logic [15:0]            divisor;
  pelt_div_req_t          div_req;
  pelt_div_rsp_t          div_rsp;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    delta   = now_r - last_time_r;
    dtot    = dsh_r + 64'(partial_r);
    periods = dtot[63:10];
    dec_res = mul_r + 64'(tmp_r);
    divisor = 16'(MIN_DIVIDER) + 16'(partial_r);
    case (sel_r)
      SEL_LOAD: dec_val = load_accum_r;
      SEL_RUN:  dec_val = runnable_accum_r;
      SEL_UTIL: dec_val = 64'(util_accum_r);
      SEL_D1:   dec_val = 64'(11'(PERIOD_UNITS) - 11'(partial_r));
      default:  dec_val = 64'(AVG_MAX);
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DEC_LO: begin
        mul_a = sh_r[31:0];
        mul_b = y_inv(pidx_r);
      end
      ST_DEC_HI: begin
        mul_a = sh_r[63:32];
        mul_b = y_inv(pidx_r);
      end
      ST_ACC_L: begin
        mul_a = 32'(load_r);
        mul_b = contrib_r;
      end
      ST_ACC_LW: begin
        mul_a = 32'(runnable_r);
        mul_b = contrib_r;
      end
      ST_LM_LO: begin
        mul_a = 32'(load_r);
        mul_b = load_accum_r[31:0];
      end
      ST_LM_HI: begin
        mul_a = 32'(load_r);
        mul_b = load_accum_r[63:32];
      end
      default: ;
    endcase
    div_req.valid    = (state_r == ST_DIVL_S) || (state_r == ST_DIVR_S) ||
                       (state_r == ST_DIVU_S);
    div_req.divisor  = divisor;
    case (state_r)
      ST_DIVR_S: div_req.dividend = runnable_accum_r;
      ST_DIVU_S: div_req.dividend = 64'(util_accum_r);
      default:   div_req.dividend = lm_r;
    endcase
  end

  pelt_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      shift_r          <= '0;
      last_time_r      <= '0;
      partial_r        <= '0;
      load_accum_r     <= '0;
      runnable_accum_r <= '0;
      util_accum_r     <= '0;
      load_mean_r      <= '0;
      runnable_mean_r  <= '0;
      util_mean_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        shift_r <= cfg_data;
      end
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            now_r      <= in_tdata[63:0];
            load_r     <= in_tdata[64 +: WEIGHT_BITS];
            runnable_r <= in_tdata[64+WEIGHT_BITS +: WEIGHT_BITS];
            running_r  <= in_tdata[64+2*WEIGHT_BITS];
            state_r    <= ST_SUB;
          end
        end
        ST_SUB: begin
          upd_r <= 1'b0;
          if (delta[63]) begin
            last_time_r <= now_r;
            state_r     <= ST_OUT;
          end else if (delta[63:10] == '0) begin
            state_r <= ST_OUT;
          end else begin
            last_time_r <= last_time_r + {delta[63:10], 10'b0};
            dsh_r       <= {10'b0, delta[63:10]} << shift_r;
            if (load_r == '0) begin
              runnable_r <= '0;
              running_r  <= 1'b0;
            end
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          contrib_r  <= dsh_r[31:0];
          rem_r      <= dtot[9:0];
          has_per_r  <= (periods != '0);
          per_zero_r <= (periods > 54'(MAX_PERIODS));
          pshift_r   <= periods[10:5];
          pidx_r     <= periods[4:0];
          sel_r      <= SEL_LOAD;
          state_r    <= (periods != '0) ? ST_DEC_SH : ST_ACC_L;
        end
        ST_DEC_SH: begin
          sh_r    <= dec_val >> pshift_r;
          state_r <= ST_DEC_LO;
        end
        ST_DEC_LO: begin
          state_r <= ST_DEC_HI;
        end
        ST_DEC_HI: begin
          tmp_r   <= mul_r[63:32];
          state_r <= ST_DEC_SUM;
        end
        ST_DEC_SUM: begin
          sel_r   <= sel_r + 3'd1;
          state_r <= (sel_r == SEL_MAX) ? ST_ACC_L : ST_DEC_SH;
          case (sel_r)
            SEL_LOAD: load_accum_r     <= per_zero_r ? '0 : dec_res;
            SEL_RUN:  runnable_accum_r <= per_zero_r ? '0 : dec_res;
            SEL_UTIL: util_accum_r     <= per_zero_r ? '0 : dec_res[31:0];
            SEL_D1:   c1_r             <= per_zero_r ? '0 : dec_res[31:0];
            default: begin
              if (load_r != '0) begin
                contrib_r <= c1_r + 32'(AVG_MAX) - (per_zero_r ? '0 : dec_res[31:0])
                             - 32'(PERIOD_UNITS) + 32'(rem_r);
              end
            end
          endcase
        end
        ST_ACC_L: begin
          partial_r <= rem_r;
          state_r   <= ST_ACC_LW;
        end
        ST_ACC_LW: begin
          load_accum_r <= load_accum_r + mul_r;
          state_r      <= ST_ACC_RW;
        end
        ST_ACC_RW: begin
          runnable_accum_r <= runnable_accum_r + (mul_r << CAP_SHIFT);
          if (running_r) begin
            util_accum_r <= util_accum_r + (contrib_r << CAP_SHIFT);
          end
          state_r <= has_per_r ? ST_LM_LO : ST_OUT;
        end
        ST_LM_LO: begin
          state_r <= ST_LM_HI;
        end
        ST_LM_HI: begin
          lm_r    <= mul_r;
          state_r <= ST_LM_SUM;
        end
        ST_LM_SUM: begin
          lm_r    <= lm_r + {mul_r[31:0], 32'b0};
          state_r <= ST_DIVL_S;
        end
        ST_DIVL_S: state_r <= ST_DIVL_W;
        ST_DIVL_W: begin
          if (div_rsp.done) begin
            load_mean_r <= div_rsp.quotient;
            state_r     <= ST_DIVR_S;
          end
        end
        ST_DIVR_S: state_r <= ST_DIVR_W;
        ST_DIVR_W: begin
          if (div_rsp.done) begin
            runnable_mean_r <= div_rsp.quotient;
            state_r         <= ST_DIVU_S;
          end
        end
        ST_DIVU_S: state_r <= ST_DIVU_W;
        ST_DIVU_W: begin
          if (div_rsp.done) begin
            util_mean_r <= div_rsp.quotient;
            upd_r       <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= upd_r;
            out_data_r  <= {util_mean_r, runnable_mean_r, load_mean_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pelt_div.sv =====
// Radix-2 restoring divider, 64-bit dividend by 16-bit divisor, one bit per cycle.
module pelt_div
  import pelt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  pelt_div_req_t req,
  output pelt_div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIV_BITS-1:0]   rem_r;
  logic [DIV_BITS-1:0]   dsr_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    ge    = (trial >= {1'b0, dsr_r});
    diff  = trial - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.valid && (cnt_r == CNT_W'(DIVIDEND_W - 1));
      if (req.valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
        quo_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[31:0];

endmodule
